// ===== src/rpr_pkg.sv =====
// ----------------------------------------------------------------------------
// rpr_pkg
// Shared types, constants and tables for the rotary position rotate block.
// ----------------------------------------------------------------------------
package rpr_pkg;

  // default parameter values
  localparam int MAX_HALF_DEF     = 128;
  localparam int CORDIC_STEPS_DEF = 24;
  localparam int POS_BITS_DEF     = 20;

  // field and port widths
  localparam int POS_W   = 20;
  localparam int VAL_W   = 32;
  localparam int HALF_W  = 8;
  localparam int RATE_W  = 40;
  localparam int RATIO_W = 32;
  localparam int CFG_W   = 40;
  localparam int IDX_W   = 2;
  localparam int IN_W    = 152;
  localparam int OUT_W   = 64;

  // datapath widths
  localparam int XY_W   = 34;
  localparam int PROD_W = 68;
  localparam int ACC_W  = 66;

  // register reset values
  localparam logic [HALF_W-1:0]  HALF_DIM_RST   = 8'd64;
  localparam logic [RATE_W-1:0]  FIRST_RATE_RST = 40'd174992710545;
  localparam logic [RATIO_W-1:0] RATE_RATIO_RST = 32'd3719287059;

  // cordic start value, gain compensation in Q2.30
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef enum logic [IDX_W-1:0] {
    REG_HALF_DIM,
    REG_FIRST_RATE,
    REG_RATE_RATIO,
    REG_INVERSE_MODE
  } reg_idx_t;

  typedef enum logic [2:0] {
    MUL_POS_LO,
    MUL_POS_HI,
    MUL_RATE_HI,
    MUL_RATE_LO,
    MUL_AC,
    MUL_BS,
    MUL_AS,
    MUL_BC
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PH_LO,
    ST_PH_HI,
    ST_RATE_HI,
    ST_RATE_LO,
    ST_SETUP,
    ST_CORDIC,
    ST_MAP,
    ST_ROT_AC,
    ST_ROT_BS,
    ST_ROT_AS,
    ST_ROT_BC,
    ST_ROT_SUM,
    ST_FINISH
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic     load;
    mul_sel_t mul_sel;
    logic     frac_lo;
    logic     frac_hi;
    logic     rate_a;
    logic     rate_b;
    logic     cordic_init;
    logic     cordic_step;
    logic     map;
    logic     r1_set;
    logic     r1_sub;
    logic     r2_set;
    logic     r2_add;
    logic     finish;
  } rpr_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic cordic_last;
    logic out_free;
  } rpr_status_t;

  // arctangent of 2^-k in Q0.32 turns
  function automatic logic [31:0] atan_turn(input logic [4:0] k);
    logic [31:0] t;
    case (k)
      5'd0:  t = 32'h20000000;
      5'd1:  t = 32'h12E4051E;
      5'd2:  t = 32'h09FB385B;
      5'd3:  t = 32'h051111D4;
      5'd4:  t = 32'h028B0D43;
      5'd5:  t = 32'h0145D7E1;
      5'd6:  t = 32'h00A2F61E;
      5'd7:  t = 32'h00517C55;
      5'd8:  t = 32'h0028BE53;
      5'd9:  t = 32'h00145F2F;
      5'd10: t = 32'h000A2F98;
      5'd11: t = 32'h000517CC;
      5'd12: t = 32'h00028BE6;
      5'd13: t = 32'h000145F3;
      5'd14: t = 32'h0000A2FA;
      5'd15: t = 32'h0000517D;
      5'd16: t = 32'h000028BE;
      5'd17: t = 32'h0000145F;
      5'd18: t = 32'h00000A30;
      5'd19: t = 32'h00000518;
      5'd20: t = 32'h0000028C;
      5'd21: t = 32'h00000146;
      5'd22: t = 32'h000000A3;
      5'd23: t = 32'h00000051;
      5'd24: t = 32'h00000029;
      5'd25: t = 32'h00000014;
      5'd26: t = 32'h0000000A;
      5'd27: t = 32'h00000005;
      5'd28: t = 32'h00000003;
      5'd29: t = 32'h00000001;
      5'd30: t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    return t;
  endfunction

endpackage

// ===== src/rotary_position_rotate.sv =====
// ----------------------------------------------------------------------------
// rotary_position_rotate
// Rotary position embedding rotation of one value pair per item.
// ----------------------------------------------------------------------------
// One item is taken at a time: a new item is taken only once the last one
// has entered the output register. The pace is set by the cordic unit,
// which runs one micro-rotation per cycle, and by the single shared
// multiplier, used four times for the phase and rate update and four times
// for the rotation. A result waiting in the output register does not hold
// up acceptance of the next item; only its final write waits for the slot.
// No clearing pass runs after reset.
module rotary_position_rotate #(
  parameter int MAX_HALF     = rpr_pkg::MAX_HALF_DEF,
  parameter int CORDIC_STEPS = rpr_pkg::CORDIC_STEPS_DEF,
  parameter int POS_BITS     = rpr_pkg::POS_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // position, first_value, second_value, first_accum, second_accum, zero pad
  input  logic [rpr_pkg::IN_W-1:0]  s_tdata,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // first_result, second_result
  output logic [rpr_pkg::OUT_W-1:0] m_tdata,
  output logic                      m_tlast,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic                      cfg_we,
  input  logic [rpr_pkg::IDX_W-1:0] cfg_index,
  input  logic [rpr_pkg::CFG_W-1:0] cfg_data
);
  import rpr_pkg::*;

  rpr_cmd_t    cmd;
  rpr_status_t status;

  // sequencer
  rpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and state
  rpr_datapath #(
    .MAX_HALF     (MAX_HALF),
    .CORDIC_STEPS (CORDIC_STEPS),
    .POS_BITS     (POS_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== src/rpr_ctrl.sv =====
// ----------------------------------------------------------------------------
// rpr_ctrl
// Sequencer that steps one item through phase, cordic and rotation.
// ----------------------------------------------------------------------------
module rpr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  rpr_pkg::rpr_status_t status,
  output rpr_pkg::rpr_cmd_t   cmd
);
  import rpr_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // no transfer is taken while reset is held
        s_tready = !rst;
        if (s_tvalid && !rst) begin
          cmd.load   = 1'b1;
          state_next = ST_PH_LO;
        end
      end
      ST_PH_LO: begin
        cmd.mul_sel = MUL_POS_LO;
        state_next  = ST_PH_HI;
      end
      ST_PH_HI: begin
        cmd.mul_sel = MUL_POS_HI;
        cmd.frac_lo = 1'b1;
        state_next  = ST_RATE_HI;
      end
      ST_RATE_HI: begin
        cmd.mul_sel = MUL_RATE_HI;
        cmd.frac_hi = 1'b1;
        state_next  = ST_RATE_LO;
      end
      ST_RATE_LO: begin
        cmd.mul_sel = MUL_RATE_LO;
        cmd.rate_a  = 1'b1;
        state_next  = ST_SETUP;
      end
      ST_SETUP: begin
        cmd.rate_b      = 1'b1;
        cmd.cordic_init = 1'b1;
        state_next      = ST_CORDIC;
      end
      ST_CORDIC: begin
        cmd.cordic_step = 1'b1;
        if (status.cordic_last) begin
          state_next = ST_MAP;
        end
      end
      ST_MAP: begin
        cmd.map    = 1'b1;
        state_next = ST_ROT_AC;
      end
      ST_ROT_AC: begin
        cmd.mul_sel = MUL_AC;
        state_next  = ST_ROT_BS;
      end
      ST_ROT_BS: begin
        cmd.mul_sel = MUL_BS;
        cmd.r1_set  = 1'b1;
        state_next  = ST_ROT_AS;
      end
      ST_ROT_AS: begin
        cmd.mul_sel = MUL_AS;
        cmd.r1_sub  = 1'b1;
        state_next  = ST_ROT_BC;
      end
      ST_ROT_BC: begin
        cmd.mul_sel = MUL_BC;
        cmd.r2_set  = 1'b1;
        state_next  = ST_ROT_SUM;
      end
      ST_ROT_SUM: begin
        cmd.r2_add = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  // an accepted item leaves the idle state at once
  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_PH_LO))
    else $error("controller did not start on accepted item");

  // results are only written into a free output slot
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> status.out_free)
    else $error("finish issued while output slot busy");

  // the cordic loop only ends through the map step
  a_cordic_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CORDIC && status.cordic_last) |=> (state == ST_MAP))
    else $error("cordic exit skipped map step");
`endif

endmodule

// ===== src/rpr_datapath.sv =====
// ----------------------------------------------------------------------------
// rpr_datapath
// Registers, shared multiplier, cordic unit, row state and output slot.
// ----------------------------------------------------------------------------
module rpr_datapath #(
  parameter int MAX_HALF     = rpr_pkg::MAX_HALF_DEF,
  parameter int CORDIC_STEPS = rpr_pkg::CORDIC_STEPS_DEF,
  parameter int POS_BITS     = rpr_pkg::POS_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [rpr_pkg::IN_W-1:0]   s_tdata,
  input  logic                       cfg_we,
  input  logic [rpr_pkg::IDX_W-1:0]  cfg_index,
  input  logic [rpr_pkg::CFG_W-1:0]  cfg_data,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [rpr_pkg::OUT_W-1:0]  m_tdata,
  output logic                       m_tlast,
  input  rpr_pkg::rpr_cmd_t          cmd,
  output rpr_pkg::rpr_status_t       status
);
  import rpr_pkg::*;

  localparam int CNT_W  = (MAX_HALF > 1) ? $clog2(MAX_HALF) : 1;
  localparam int ITER_W = $clog2(CORDIC_STEPS);
  localparam logic [POS_W-1:0] POS_MASK =
    (POS_BITS >= POS_W) ? '1 : POS_W'((64'd1 << POS_BITS) - 64'd1);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);
  localparam logic [31:0] HALF_MAX = 32'(MAX_HALF);

  // configuration and row state
  logic [HALF_W-1:0]  half_dim;
  logic [RATE_W-1:0]  first_rate;
  logic [RATIO_W-1:0] rate_ratio;
  logic               inverse_mode;
  logic [CNT_W-1:0]   pair_counter;
  logic [RATE_W-1:0]  rate_now;

  // item registers
  logic [POS_W-1:0]        pos_r;
  logic signed [VAL_W-1:0] a_r, b_r, fa_r, fb_r;

  // work registers
  logic signed [XY_W-1:0]   op_a, op_b;
  logic signed [PROD_W-1:0] prod;
  logic [RATE_W-1:0]        frac;
  logic [51:0]              rta;
  logic [RATE_W-1:0]        rnew;
  logic [71:0]              rsum;
  logic [31:0]              phase;
  logic [1:0]               quad, q_r;
  logic [31:0]              resid;
  logic signed [XY_W-1:0]   x, y, z, dx, dy, atan_v;
  logic [ITER_W-1:0]        iter;
  logic signed [XY_W-1:0]   c_r, s_r;
  logic signed [ACC_W-1:0]  r1, r2;
  logic signed [ACC_W-1:0]  v1, v2;
  logic [VAL_W-1:0]         res1, res2;
  logic [31:0]              h_eff;
  logic                     last_pair;
  logic                     out_valid;

  // shared multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.mul_sel)
      MUL_POS_LO: begin
        op_a = XY_W'(pos_r);
        op_b = XY_W'(rate_now[19:0]);
      end
      MUL_POS_HI: begin
        op_a = XY_W'(pos_r);
        op_b = XY_W'(rate_now[39:20]);
      end
      MUL_RATE_HI: begin
        op_a = XY_W'(rate_now[39:20]);
        op_b = XY_W'(rate_ratio);
      end
      MUL_RATE_LO: begin
        op_a = XY_W'(rate_now[19:0]);
        op_b = XY_W'(rate_ratio);
      end
      MUL_AC: begin
        op_a = XY_W'(a_r);
        op_b = c_r;
      end
      MUL_BS: begin
        op_a = XY_W'(b_r);
        op_b = s_r;
      end
      MUL_AS: begin
        op_a = XY_W'(a_r);
        op_b = s_r;
      end
      MUL_BC: begin
        op_a = XY_W'(b_r);
        op_b = c_r;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

  // phase split into quadrant and residual, rate sum and cordic shift terms
  always_comb begin
    phase = frac[39:8];
    quad  = 2'((phase + 32'h2000_0000) >> 30);
    resid = phase - {quad, 30'd0};
    rsum  = {rta, 20'd0} + 72'(prod[51:0]);
    dx     = y >>> iter;
    dy     = x >>> iter;
    atan_v = XY_W'(atan_turn(5'(iter)));
  end

  // item, phase, rate update, cordic, map and rotation registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_r <= s_tdata[19:0] & POS_MASK;
      a_r   <= s_tdata[51:20];
      b_r   <= s_tdata[83:52];
      fa_r  <= s_tdata[115:84];
      fb_r  <= s_tdata[147:116];
    end
    if (cmd.frac_lo) begin
      frac <= prod[39:0];
    end
    if (cmd.frac_hi) begin
      frac <= frac + {prod[19:0], 20'd0};
    end
    if (cmd.rate_a) begin
      rta <= prod[51:0];
    end
    if (cmd.rate_b) begin
      rnew <= rsum[71:32];
    end
    if (cmd.cordic_init) begin
      q_r <= quad;
      x   <= CORDIC_GAIN;
      y   <= '0;
      z   <= XY_W'(signed'(resid));
    end
    if (cmd.cordic_step) begin
      if (!z[XY_W-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - atan_v;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + atan_v;
      end
    end
    if (cmd.map) begin
      case (q_r)
        2'd0: begin
          c_r <= x;
          s_r <= inverse_mode ? -y : y;
        end
        2'd1: begin
          c_r <= -y;
          s_r <= inverse_mode ? -x : x;
        end
        2'd2: begin
          c_r <= -x;
          s_r <= inverse_mode ? y : -y;
        end
        default: begin
          c_r <= y;
          s_r <= inverse_mode ? x : -x;
        end
      endcase
    end
    if (cmd.r1_set) begin
      r1 <= prod[ACC_W-1:0];
    end
    if (cmd.r1_sub) begin
      r1 <= r1 - prod[ACC_W-1:0];
    end
    if (cmd.r2_set) begin
      r2 <= prod[ACC_W-1:0];
    end
    if (cmd.r2_add) begin
      r2 <= r2 + prod[ACC_W-1:0];
    end
  end

  // cordic iteration counter
  always_ff @(posedge clk) begin
    if (rst) begin
      iter <= '0;
    end else if (cmd.cordic_init) begin
      iter <= '0;
    end else if (cmd.cordic_step) begin
      iter <= iter + ITER_W'(1);
    end
  end

  // rounding, accumulate and saturation
  always_comb begin
    v1 = ((r1 + ACC_W'(32'sh2000_0000)) >>> 30)
         + (inverse_mode ? ACC_W'(fa_r) : ACC_W'(0));
    v2 = ((r2 + ACC_W'(32'sh2000_0000)) >>> 30)
         + (inverse_mode ? ACC_W'(fb_r) : ACC_W'(0));
    if (v1 > ACC_W'(32'sh7FFF_FFFF)) begin
      res1 = 32'h7FFF_FFFF;
    end else if (v1 < ACC_W'(32'sh8000_0000)) begin
      res1 = 32'h8000_0000;
    end else begin
      res1 = v1[31:0];
    end
    if (v2 > ACC_W'(32'sh7FFF_FFFF)) begin
      res2 = 32'h7FFF_FFFF;
    end else if (v2 < ACC_W'(32'sh8000_0000)) begin
      res2 = 32'h8000_0000;
    end else begin
      res2 = v2[31:0];
    end
  end

  // end of row test with clamped half_dim
  always_comb begin
    if (half_dim == '0) begin
      h_eff = 32'd1;
    end else if (32'(half_dim) > HALF_MAX) begin
      h_eff = HALF_MAX;
    end else begin
      h_eff = 32'(half_dim);
    end
    last_pair = (32'(pair_counter) + 32'd1) >= h_eff;
  end

  // configuration registers and row state
  always_ff @(posedge clk) begin
    if (rst) begin
      half_dim     <= HALF_DIM_RST;
      first_rate   <= FIRST_RATE_RST;
      rate_ratio   <= RATE_RATIO_RST;
      inverse_mode <= 1'b0;
      pair_counter <= '0;
      rate_now     <= FIRST_RATE_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_HALF_DIM: begin
          half_dim     <= cfg_data[7:0];
          pair_counter <= '0;
          rate_now     <= first_rate;
        end
        REG_FIRST_RATE: begin
          first_rate   <= cfg_data[39:0];
          pair_counter <= '0;
          rate_now     <= cfg_data[39:0];
        end
        REG_RATE_RATIO: begin
          rate_ratio   <= cfg_data[31:0];
          pair_counter <= '0;
          rate_now     <= first_rate;
        end
        REG_INVERSE_MODE: begin
          inverse_mode <= cfg_data[0];
        end
        default: begin
          inverse_mode <= inverse_mode;
        end
      endcase
    end else if (cmd.finish) begin
      if (last_pair) begin
        pair_counter <= '0;
        rate_now     <= first_rate;
      end else begin
        pair_counter <= pair_counter + CNT_W'(1);
        rate_now     <= rnew;
      end
    end
  end

  // output slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tdata <= {res2, res1};
      m_tlast <= last_pair;
    end
  end

  assign m_tvalid           = out_valid;
  assign status.out_free    = !out_valid || m_tready;
  assign status.cordic_last = (iter == ITER_LAST);

`ifndef ASSERT_OFF
  // a finished item always shows up in the output slot
  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && !cfg_we) |=> m_tvalid)
    else $error("finished item missing from output slot");

  // the end of a row restarts the pair walk
  a_row_restart: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && !cfg_we && last_pair) |=>
      (pair_counter == '0) && (rate_now == first_rate))
    else $error("row end did not restart pair walk");

  // the cordic counter stays within its step count
  a_iter_range: assert property (@(posedge clk) disable iff (rst)
    cmd.cordic_step |-> (iter <= ITER_LAST))
    else $error("cordic iteration counter out of range");
`endif

endmodule

// ===== bench/tb_rotary_position_rotate.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rotary_position_rotate
// Self-checking bench for the rotary position rotate block: directed corner
// items, row length and rate register sweeps, both rotation directions, then
// random traffic with random stalls on both streams, checked against an
// in-bench predictor of the rotation arithmetic.
// ----------------------------------------------------------------------------
module tb_rotary_position_rotate;
  import rpr_pkg::*;

  typedef struct packed {
    logic signed [31:0] res_b;
    logic signed [31:0] res_a;
    logic               row_last;
  } rot_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic [IN_W-1:0]      s_tdata = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [OUT_W-1:0]     m_tdata;
  logic                 m_tlast;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [IDX_W-1:0]     cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // predictor copy of registers and row state
  logic [7:0]           pm_half;
  logic [39:0]          pm_first_rate;
  logic [31:0]          pm_ratio;
  logic                 pm_inverse;
  int unsigned          pm_pair;
  logic [39:0]          pm_rate;

  rot_result_t          pending_q[$];
  int                   err_count = 0;
  int                   sent_count = 0;
  int                   got_count = 0;
  int                   idle_cycles = 0;
  bit                   no_stall = 1'b0;

  localparam int WATCHDOG = 20000;

  always #5 clk = ~clk;

  rotary_position_rotate u_top (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tlast(m_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // cosine and sine of a Q0.32 phase, Q2.30
  function automatic void phase_sincos(input logic [31:0] ph,
                                       output longint c, output longint s);
    logic [1:0]  quad;
    logic [31:0] resid;
    longint      x, y, z, dx, dy;
    quad  = 2'((ph + 32'h20000000) >> 30);
    resid = ph - {quad, 30'd0};
    z = longint'(signed'(resid));
    x = 652032874;
    y = 0;
    for (int k = 0; k < CORDIC_STEPS_DEF; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_turn(5'(k)));
      end else begin
        x += dx; y -= dy; z += longint'(atan_turn(5'(k)));
      end
    end
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic logic [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // expected rotation of one pair, advances row state
  function automatic rot_result_t rotate_pair(input logic [19:0] pos,
      input logic signed [31:0] va, vb, fa, fb);
    rot_result_t r;
    logic [79:0]  prod;
    logic [71:0]  rp;
    longint       c, s, r1, r2;
    int unsigned  h;
    prod = 80'(pos) * 80'(pm_rate);
    phase_sincos(prod[39:8], c, s);
    if (pm_inverse) s = -s;
    r1 = (longint'(va) * c - longint'(vb) * s + 64'sd536870912) >>> 30;
    r2 = (longint'(va) * s + longint'(vb) * c + 64'sd536870912) >>> 30;
    if (pm_inverse) begin
      r1 += longint'(fa); r2 += longint'(fb);
    end
    h = pm_half;
    if (h < 1) h = 1;
    if (h > MAX_HALF_DEF) h = MAX_HALF_DEF;
    r.row_last = (pm_pair + 1 >= h);
    if (r.row_last) begin
      pm_pair = 0; pm_rate = pm_first_rate;
    end else begin
      pm_pair++;
      rp = 72'(pm_rate) * 72'(pm_ratio);
      pm_rate = rp[71:32];
    end
    r.res_a = clip32(r1);
    r.res_b = clip32(r2);
    return r;
  endfunction

  // register write, only while idle
  task automatic write_reg(input reg_idx_t idx, input logic [39:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_HALF_DIM:   begin pm_half = val[7:0]; pm_pair = 0; pm_rate = pm_first_rate; end
      REG_FIRST_RATE: begin pm_first_rate = val; pm_pair = 0; pm_rate = val; end
      REG_RATE_RATIO: begin pm_ratio = val[31:0]; pm_pair = 0; pm_rate = pm_first_rate; end
      default:        pm_inverse = val[0];
    endcase
    @(posedge clk);
  endtask

  // one input transfer
  task automatic send_pair(input logic [19:0] pos, input logic [31:0] va, vb, fa, fb);
    while (!no_stall && $urandom_range(99) < 29) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata  <= {24'd0, fb, fa, vb, va, pos};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    pending_q.push_back(rotate_pair(pos, va, vb, fa, fb));
    sent_count++;
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(262143) - 131072;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++)
      send_pair(($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(4095)),
                rand_val(), rand_val(), rand_val(), rand_val());
  endtask

  task automatic test_corners();
    send_pair(20'd0, 32'h00010000, 32'h00000000, 32'd0, 32'd0);
    send_pair(20'hFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_pair(20'hFFFFF, 32'h80000000, 32'h80000000, 32'd0, 32'd0);
    send_pair(20'd1, 32'h80000000, 32'h7FFFFFFF, 32'h12345678, 32'h87654321);
    send_pair(20'd7, 32'hFFFFFFFF, 32'h00000001, 32'd0, 32'd0);
    drain();
  endtask

  task automatic test_quadrants();
    // eighth-turn phases land exactly on each quadrant centre and edge
    write_reg(REG_HALF_DIM, 40'd1);
    for (int q = 0; q < 8; q++) begin
      write_reg(REG_FIRST_RATE, 40'(q) << 37);
      send_pair(20'd1, 32'h00010000, 32'h00020000, 32'd0, 32'd0);
      drain();
    end
  endtask

  task automatic test_inverse();
    write_reg(REG_INVERSE_MODE, 40'd1);
    write_reg(REG_HALF_DIM, 40'd4);
    write_reg(REG_FIRST_RATE, 40'hFFFFFFFFFF);
    write_reg(REG_RATE_RATIO, 40'hFFFFFFFF);
    send_pair(20'hFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_pair(20'hFFFFF, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send_random(6);
    drain();
    // fresh row after a row length change
    write_reg(REG_HALF_DIM, 40'd8);
    send_random(5);
    drain();
    write_reg(REG_INVERSE_MODE, 40'd0);
    send_random(3);
    drain();
  endtask

  task automatic test_row_sweep();
    logic [7:0] halves[6] = '{8'd0, 8'd1, 8'd3, 8'd128, 8'd200, 8'd255};
    foreach (halves[i]) begin
      write_reg(REG_HALF_DIM, 40'(halves[i]));
      write_reg(REG_RATE_RATIO, (i % 2) ? 40'd0 : 40'(RATE_RATIO_RST));
      write_reg(REG_FIRST_RATE, (i == 2) ? 40'd0 : 40'(FIRST_RATE_RST));
      write_reg(REG_INVERSE_MODE, 40'(i % 2));
      send_random((halves[i] > 8'd3) ? 130 : 20);
      drain();
    end
  endtask

  task automatic test_random();
    write_reg(REG_HALF_DIM, 40'd16);
    write_reg(REG_FIRST_RATE, 40'(FIRST_RATE_RST));
    write_reg(REG_RATE_RATIO, 40'(RATE_RATIO_RST));
    send_random(300);
    // stretch without random stalls
    no_stall = 1'b1;
    send_random(150);
    no_stall = 1'b0;
    drain();
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_HALF_DIM, 40'($urandom_range(1, 40)));
      write_reg(REG_FIRST_RATE, {8'($urandom), 32'($urandom)});
      write_reg(REG_RATE_RATIO, 40'($urandom));
      write_reg(REG_INVERSE_MODE, 40'($urandom_range(1)));
      send_random(120);
      drain();
    end
  endtask

  // result side backpressure
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= no_stall || ($urandom_range(99) >= 29);
  end

  // compare each result transfer with the oldest expected one
  always @(posedge clk) begin
    rot_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      got_count++;
      if (pending_q.size() == 0) begin
        $error("unexpected result transfer data=%h", m_tdata);
        err_count++;
      end else begin
        e = pending_q.pop_front();
        if (m_tdata[31:0] !== e.res_a) begin
          $error("first_result expected %h actual %h", e.res_a, m_tdata[31:0]);
          err_count++;
        end
        if (m_tdata[63:32] !== e.res_b) begin
          $error("second_result expected %h actual %h", e.res_b, m_tdata[63:32]);
          err_count++;
        end
        if (m_tlast !== e.row_last) begin
          $error("row_end expected %b actual %b", e.row_last, m_tlast);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG);
      $display("tb_rotary_position_rotate: errors");
      $finish;
    end
  end

  initial begin
    pm_half = HALF_DIM_RST; pm_first_rate = FIRST_RATE_RST; pm_ratio = RATE_RATIO_RST;
    pm_inverse = 1'b0; pm_pair = 0; pm_rate = FIRST_RATE_RST;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corners();
    test_quadrants();
    test_inverse();
    test_row_sweep();
    test_random();
    drain();
    if (pending_q.size() != 0) begin
      $error("%0d expected results never arrived", pending_q.size());
      err_count++;
    end
    $display("covered %0d pair transfers and %0d results, both directions,", sent_count,
             got_count);
    $display("row lengths 0 to 255, rate extremes and random stalls");
    if (err_count == 0)
      $display("tb_rotary_position_rotate: clean");
    else
      $display("tb_rotary_position_rotate: errors");
    $finish;
  end

endmodule

// ===== files.f =====
src/rpr_pkg.sv
src/rpr_ctrl.sv
src/rpr_datapath.sv
src/rotary_position_rotate.sv
bench/tb_rotary_position_rotate.sv
